// File: src/tfrs_pkg.sv
`default_nettype none
// ============================================================================
// tfrs_pkg
// Shared types, constants and the control program of the frame ring selector.
// ============================================================================
package tfrs_pkg;

    // Defaults for the top-level parameters.
    localparam int DEF_SLOTS      = 16;
    localparam int DEF_STAMP_BITS = 48;

    // Fixed field widths.
    localparam int ACTION_BITS   = 3;
    localparam int SLOT_OUT_BITS = 4;
    localparam int FLAG_BITS     = 2;

    // Action codes carried in the input tuser.
    localparam logic [ACTION_BITS-1:0] ACT_INSERT  = 3'd0;
    localparam logic [ACTION_BITS-1:0] ACT_SELECT  = 3'd1;
    localparam logic [ACTION_BITS-1:0] ACT_ADVANCE = 3'd2;
    localparam logic [ACTION_BITS-1:0] ACT_SEEK    = 3'd3;
    localparam logic [ACTION_BITS-1:0] ACT_CLEAR   = 3'd4;

    // Program steps. Fall-through goes to the next member in this order.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_INS,
        ST_SEL_INIT,
        ST_SEL_DIFF,
        ST_SEL_CMP,
        ST_SEL_FIN,
        ST_ADV,
        ST_SEEK_RD,
        ST_SEEK_LO,
        ST_SEEK_HI,
        ST_CLR,
        ST_RD_OUT,
        ST_OUT
    } step_t;

    // Datapath operation of one step.
    typedef enum logic [3:0] {
        OP_NONE,
        OP_ACCEPT,
        OP_INSERT,
        OP_SEL_INIT,
        OP_SEL_DIFF,
        OP_SEL_CMP,
        OP_SEL_FIN,
        OP_ADVANCE,
        OP_SEEK_LO,
        OP_SEEK_HI,
        OP_CLEAR,
        OP_OUTPUT
    } dp_op_t;

    // Store read address source.
    typedef enum logic [1:0] {
        RD_NONE,
        RD_USE,
        RD_CUR_NEXT,
        RD_NEWEST
    } rd_sel_t;

    // Sequencing of the step counter.
    typedef enum logic [2:0] {
        J_NEXT,
        J_GOTO,
        J_DISPATCH,
        J_IF_MORE,
        J_WAIT_OUT
    } jmp_t;

    // One control word of the program.
    typedef struct packed {
        dp_op_t  op;
        rd_sel_t rd;
        jmp_t    jmp;
        step_t   target;
    } ctrl_word_t;

    // Conditions that the datapath hands to the sequencer.
    typedef struct packed {
        logic in_accept;
        logic more;
        logic out_free;
    } seq_cond_t;

    // The control program.
    function automatic ctrl_word_t ucode_rom(step_t s);
        ctrl_word_t cw;
        cw = '{op: OP_NONE, rd: RD_NONE, jmp: J_NEXT, target: ST_IDLE};
        unique case (s)
            ST_IDLE:     cw = '{op: OP_ACCEPT,   rd: RD_NONE,     jmp: J_DISPATCH,
                                target: ST_IDLE};
            ST_INS:      cw = '{op: OP_INSERT,   rd: RD_NONE,     jmp: J_GOTO,
                                target: ST_RD_OUT};
            ST_SEL_INIT: cw = '{op: OP_SEL_INIT, rd: RD_USE,      jmp: J_NEXT,
                                target: ST_IDLE};
            ST_SEL_DIFF: cw = '{op: OP_SEL_DIFF, rd: RD_CUR_NEXT, jmp: J_NEXT,
                                target: ST_IDLE};
            ST_SEL_CMP:  cw = '{op: OP_SEL_CMP,  rd: RD_NONE,     jmp: J_IF_MORE,
                                target: ST_SEL_DIFF};
            ST_SEL_FIN:  cw = '{op: OP_SEL_FIN,  rd: RD_NONE,     jmp: J_GOTO,
                                target: ST_RD_OUT};
            ST_ADV:      cw = '{op: OP_ADVANCE,  rd: RD_NONE,     jmp: J_GOTO,
                                target: ST_RD_OUT};
            ST_SEEK_RD:  cw = '{op: OP_NONE,     rd: RD_USE,      jmp: J_NEXT,
                                target: ST_IDLE};
            ST_SEEK_LO:  cw = '{op: OP_SEEK_LO,  rd: RD_NEWEST,   jmp: J_NEXT,
                                target: ST_IDLE};
            ST_SEEK_HI:  cw = '{op: OP_SEEK_HI,  rd: RD_NONE,     jmp: J_GOTO,
                                target: ST_RD_OUT};
            ST_CLR:      cw = '{op: OP_CLEAR,    rd: RD_NONE,     jmp: J_NEXT,
                                target: ST_IDLE};
            ST_RD_OUT:   cw = '{op: OP_NONE,     rd: RD_USE,      jmp: J_NEXT,
                                target: ST_IDLE};
            ST_OUT:      cw = '{op: OP_OUTPUT,   rd: RD_NONE,     jmp: J_WAIT_OUT,
                                target: ST_IDLE};
            default:     cw = '{op: OP_NONE,     rd: RD_NONE,     jmp: J_GOTO,
                                target: ST_IDLE};
        endcase
        return cw;
    endfunction

endpackage
`default_nettype wire

// File: src/timestamped_frame_ring_selector_top.sv
`default_nettype none
// ============================================================================
// timestamped_frame_ring_selector_top
// Ring of decoded-frame timestamps with insert, nearest select, advance,
// seek and clear, run by a small control program.
// ============================================================================
//
// Channel  Dir  Signals                              Contents
// s_*      in   s_tvalid s_tready s_tdata s_tuser    stamp / action
// m_*      out  m_tvalid m_tready m_tdata m_tuser    slot, stamp, lead / flags
//
// One transaction in gives one transaction out. Select scans the slots from
// in-use through newest (at most SLOTS-1): each slot costs one store read
// plus one distance compare. Reset restores the pointers at once; store
// entries read as minus one until written. A result waits in its output
// register while m_tready is low, and the program holds at its last step
// until the register is free.
//
module timestamped_frame_ring_selector_top
    import tfrs_pkg::*;
#(
    parameter int SLOTS      = DEF_SLOTS,
    parameter int STAMP_BITS = DEF_STAMP_BITS
) (
    input  wire logic                                         clk,
    input  wire logic                                         rst_n,
    input  wire logic                                         s_tvalid,
    output logic                                              s_tready,
    // stamp
    input  wire logic [((STAMP_BITS+7)/8)*8-1:0]              s_tdata,
    // action
    input  wire logic [ACTION_BITS-1:0]                       s_tuser,
    output logic                                              m_tvalid,
    input  wire logic                                         m_tready,
    // slot, slot_stamp, lead_time
    output logic [((SLOT_OUT_BITS+2*STAMP_BITS+1+7)/8)*8-1:0] m_tdata,
    // refused, seek_needed
    output logic [FLAG_BITS-1:0]                              m_tuser
);

    localparam int PTR_BITS      = $clog2(SLOTS);
    localparam int OUT_DATA_BITS = ((SLOT_OUT_BITS + 2*STAMP_BITS + 1 + 7) / 8) * 8;
    localparam int WIDE_BITS     = (PTR_BITS > SLOT_OUT_BITS) ? PTR_BITS : SLOT_OUT_BITS;
    localparam logic [PTR_BITS-1:0] LAST_SLOT = PTR_BITS'(SLOTS - 1);

    function automatic logic [PTR_BITS-1:0] next_slot(logic [PTR_BITS-1:0] s);
        return (s == LAST_SLOT) ? '0 : s + 1'b1;
    endfunction

    ctrl_word_t ctrl;
    seq_cond_t  cond;

    logic [PTR_BITS-1:0]   in_use_reg, in_use_next;
    logic [PTR_BITS-1:0]   wp_reg, wp_next;
    logic [STAMP_BITS-1:0] last_req_reg, last_req_next;
    logic [STAMP_BITS-1:0] t_reg, t_next;
    logic [PTR_BITS-1:0]   cur_reg, cur_next;
    logic [PTR_BITS-1:0]   best_reg, best_next;
    logic [STAMP_BITS:0]   best_d_reg, best_d_next;
    logic [STAMP_BITS:0]   d_reg, d_next;
    logic                  lo_ok_reg, lo_ok_next;
    logic                  refused_reg, refused_next;
    logic                  seek_reg, seek_next;
    logic [STAMP_BITS:0]   lead_reg, lead_next;
    logic                  out_valid_reg, out_valid_next;
    logic [OUT_DATA_BITS-1:0] out_data_reg, out_data_next;
    logic [FLAG_BITS-1:0]  out_user_reg, out_user_next;

    logic                  in_accept;
    logic                  wr_en;
    logic                  rd_en;
    logic [PTR_BITS-1:0]   rd_addr;
    logic [STAMP_BITS-1:0] rd_data;
    logic [PTR_BITS-1:0]   newest;
    logic [STAMP_BITS:0]   ext_rd, ext_t, ext_lr;
    logic [STAMP_BITS:0]   diff_rt, diff_tr, diff_abs, lead_diff;
    logic [WIDE_BITS-1:0]  use_wide;

    // Handshake and sequencer conditions.
    assign s_tready       = (ctrl.op == OP_ACCEPT);
    assign in_accept      = s_tvalid && s_tready;
    assign newest         = (wp_reg == '0) ? LAST_SLOT : wp_reg - 1'b1;
    assign cond.in_accept = in_accept;
    assign cond.more      = (cur_reg != newest);
    assign cond.out_free  = !out_valid_reg || m_tready;

    tfrs_sequencer u_seq (
        .clk    (clk),
        .rst_n  (rst_n),
        .action (s_tuser),
        .cond   (cond),
        .ctrl   (ctrl)
    );

    // Store read address selection.
    always_comb
    begin
        rd_en   = 1'b1;
        rd_addr = in_use_reg;
        unique case (ctrl.rd)
            RD_NONE:     rd_en   = 1'b0;
            RD_USE:      rd_addr = in_use_reg;
            RD_CUR_NEXT: rd_addr = next_slot(cur_reg);
            RD_NEWEST:   rd_addr = newest;
            default:     rd_en   = 1'b0;
        endcase
    end

    assign wr_en = (ctrl.op == OP_INSERT) && !t_reg[STAMP_BITS-1]
                   && (next_slot(wp_reg) != in_use_reg);

    tfrs_store #(
        .SLOTS      (SLOTS),
        .STAMP_BITS (STAMP_BITS)
    ) u_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (wr_en),
        .wr_addr (wp_reg),
        .wr_data (t_reg),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Arithmetic on sign-extended stamps.
    assign ext_rd    = {rd_data[STAMP_BITS-1], rd_data};
    assign ext_t     = {t_reg[STAMP_BITS-1], t_reg};
    assign ext_lr    = {last_req_reg[STAMP_BITS-1], last_req_reg};
    assign diff_rt   = ext_rd - ext_t;
    assign diff_tr   = ext_t - ext_rd;
    assign diff_abs  = diff_rt[STAMP_BITS] ? diff_tr : diff_rt;
    assign lead_diff = ext_t - ext_lr;
    assign use_wide  = WIDE_BITS'(in_use_reg);

    // Datapath next values, one operation per control word.
    always_comb
    begin
        in_use_next    = in_use_reg;
        wp_next        = wp_reg;
        last_req_next  = last_req_reg;
        t_next         = t_reg;
        cur_next       = cur_reg;
        best_next      = best_reg;
        best_d_next    = best_d_reg;
        d_next         = d_reg;
        lo_ok_next     = lo_ok_reg;
        refused_next   = refused_reg;
        seek_next      = seek_reg;
        lead_next      = lead_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        out_user_next  = out_user_reg;

        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (ctrl.op)
            OP_NONE:
            begin
            end
            OP_ACCEPT:
            begin
                if (in_accept)
                begin
                    t_next       = s_tdata[STAMP_BITS-1:0];
                    refused_next = 1'b0;
                    seek_next    = 1'b0;
                    lead_next    = '0;
                end
            end
            OP_INSERT:
            begin
                if (wr_en)
                begin
                    wp_next   = next_slot(wp_reg);
                    lead_next = lead_diff;
                end
                else
                begin
                    refused_next = 1'b1;
                end
            end
            OP_SEL_INIT:
            begin
                last_req_next = t_reg;
                cur_next      = in_use_reg;
                best_next     = in_use_reg;
                best_d_next   = '1;
            end
            OP_SEL_DIFF:
            begin
                d_next = diff_abs;
            end
            OP_SEL_CMP:
            begin
                // Strict compare keeps the earlier slot on a tie.
                if (d_reg < best_d_reg)
                begin
                    best_d_next = d_reg;
                    best_next   = cur_reg;
                end
                if (cond.more)
                begin
                    cur_next = next_slot(cur_reg);
                end
            end
            OP_SEL_FIN:
            begin
                in_use_next = best_reg;
            end
            OP_ADVANCE:
            begin
                if (next_slot(in_use_reg) != wp_reg)
                begin
                    in_use_next = next_slot(in_use_reg);
                end
            end
            OP_SEEK_LO:
            begin
                lo_ok_next = ($signed(rd_data) < $signed(t_reg));
            end
            OP_SEEK_HI:
            begin
                // A hit needs a buffered span that strictly contains the time.
                if (!((newest != in_use_reg) && lo_ok_reg
                      && ($signed(t_reg) < $signed(rd_data))))
                begin
                    wp_next       = next_slot(in_use_reg);
                    last_req_next = t_reg;
                    seek_next     = 1'b1;
                end
            end
            OP_CLEAR:
            begin
                in_use_next = LAST_SLOT;
                wp_next     = '0;
            end
            OP_OUTPUT:
            begin
                if (cond.out_free)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = OUT_DATA_BITS'({lead_reg, rd_data,
                                                     use_wide[SLOT_OUT_BITS-1:0]});
                    out_user_next  = {seek_reg, refused_reg};
                end
            end
            default:
            begin
            end
        endcase
    end

    // Control state and pointers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_use_reg    <= LAST_SLOT;
            wp_reg        <= '0;
            last_req_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_use_reg    <= in_use_next;
            wp_reg        <= wp_next;
            last_req_reg  <= last_req_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Working and result payload registers.
    always_ff @(posedge clk)
    begin
        t_reg        <= t_next;
        cur_reg      <= cur_next;
        best_reg     <= best_next;
        best_d_reg   <= best_d_next;
        d_reg        <= d_next;
        lo_ok_reg    <= lo_ok_next;
        refused_reg  <= refused_next;
        seek_reg     <= seek_next;
        lead_reg     <= lead_next;
        out_data_reg <= out_data_next;
        out_user_reg <= out_user_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

endmodule
`default_nettype wire

// File: src/tfrs_store.sv
`default_nettype none
// ============================================================================
// tfrs_store
// Timestamp store: one write and one registered read per cycle. Entries that
// were never written read as all ones.
// ============================================================================
module tfrs_store
    import tfrs_pkg::*;
#(
    parameter int SLOTS      = DEF_SLOTS,
    parameter int STAMP_BITS = DEF_STAMP_BITS
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(SLOTS)-1:0] wr_addr,
    input  wire logic [STAMP_BITS-1:0]    wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(SLOTS)-1:0] rd_addr,
    output logic      [STAMP_BITS-1:0]    rd_data
);

    logic [STAMP_BITS-1:0] mem [SLOTS];
    logic [SLOTS-1:0]      valid_reg;
    logic [SLOTS-1:0]      valid_next;
    logic [STAMP_BITS-1:0] rd_data_reg;
    logic                  rd_valid_reg;
    logic                  rd_valid_next;

    // Array write and registered read.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // Valid bits: set on write, cleared by reset only.
    always_comb
    begin
        valid_next    = valid_reg;
        rd_valid_next = rd_valid_reg;
        if (wr_en)
        begin
            valid_next[wr_addr] = 1'b1;
        end
        if (rd_en)
        begin
            rd_valid_next = valid_reg[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg    <= valid_next;
            rd_valid_reg <= rd_valid_next;
        end
    end

    // An entry not written since reset reads as minus one.
    assign rd_data = rd_valid_reg ? rd_data_reg : '1;

endmodule
`default_nettype wire

// File: src/tfrs_sequencer.sv
`default_nettype none
// ============================================================================
// tfrs_sequencer
// Step counter over the control program, with dispatch and conditional jumps.
// ============================================================================
module tfrs_sequencer
    import tfrs_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic [ACTION_BITS-1:0] action,
    input  wire seq_cond_t              cond,
    output ctrl_word_t                  ctrl
);

    step_t step_reg;
    step_t step_next;

    // Control word of the current step.
    always_comb
    begin
        ctrl = ucode_rom(step_reg);
    end

    // Next step.
    always_comb
    begin
        step_next = step_reg;
        unique case (ctrl.jmp)
            J_NEXT:
            begin
                step_next = step_t'(step_reg + 4'd1);
            end
            J_GOTO:
            begin
                step_next = ctrl.target;
            end
            J_DISPATCH:
            begin
                if (cond.in_accept)
                begin
                    unique case (action)
                        ACT_INSERT:  step_next = ST_INS;
                        ACT_SELECT:  step_next = ST_SEL_INIT;
                        ACT_ADVANCE: step_next = ST_ADV;
                        ACT_SEEK:    step_next = ST_SEEK_RD;
                        ACT_CLEAR:   step_next = ST_CLR;
                        default:     step_next = ST_RD_OUT;
                    endcase
                end
            end
            J_IF_MORE:
            begin
                step_next = cond.more ? ctrl.target : step_t'(step_reg + 4'd1);
            end
            J_WAIT_OUT:
            begin
                if (cond.out_free)
                begin
                    step_next = ctrl.target;
                end
            end
            default:
            begin
                step_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= ST_IDLE;
        end
        else
        begin
            step_reg <= step_next;
        end
    end

endmodule
`default_nettype wire
